FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant check failed");

`endif

FILE: rtl/ptpc_pkg.sv
package ptpc_pkg;

	localparam int XW = 36;          // CORDIC x/y datapath
	localparam int ZW = 35;          // Q30 angle accumulator
	localparam int ATAN_LEN = 24;
	localparam int DEF_CORDIC_STEPS = 16;

	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_LEN] = '{
		35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
		35'sd67021687, 35'sd33543516, 35'sd16775851, 35'sd8388437,
		35'sd4194283, 35'sd2097149, 35'sd1048575, 35'sd524288,
		35'sd262144, 35'sd131072, 35'sd65536, 35'sd32768,
		35'sd16384, 35'sd8192, 35'sd4096, 35'sd2048,
		35'sd1024, 35'sd512, 35'sd256, 35'sd128
	};

	typedef struct packed {
		logic                  valid;
		logic                  zero;   // input vector was (0,0)
		logic signed [XW-1:0]  x;
		logic signed [XW-1:0]  y;
		logic signed [ZW-1:0]  z;
	} vec_t;

	// Pre-rotation by pi for the left half plane.
	function automatic vec_t cordic_prep(logic signed [XW-1:0] x, logic signed [XW-1:0] y);
		vec_t v;
		v.valid = 1'b1;
		v.zero  = (x == '0) && (y == '0);
		if (x < 0) begin
			v.x = -x;
			v.y = -y;
			v.z = (y >= 0) ? PI_Q30 : -PI_Q30;
		end else begin
			v.x = x;
			v.y = y;
			v.z = '0;
		end
		return v;
	endfunction

	// Q30 radians to Q4.12, round half up.
	function automatic logic [15:0] q30_to_q12(logic signed [XW-1:0] a);
		logic signed [XW-1:0] t;
		t = (a + 36'sd131072) >>> 18;
		return t[15:0];
	endfunction

endpackage

FILE: rtl/ptpc_cordic_cell.sv
module ptpc_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ptpc_pkg::vec_t   din,
	output ptpc_pkg::vec_t   dout
);
	import ptpc_pkg::*;

	logic                  valid_q;
	logic                  zero_q;
	logic signed [XW-1:0]  x_q;
	logic signed [XW-1:0]  y_q;
	logic signed [ZW-1:0]  z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	// one micro-rotation, direction from the sign of y
	always_ff @(posedge clk) begin
		zero_q <= din.zero;
		if (din.y > 0) begin
			x_q <= din.x + (din.y >>> IDX);
			y_q <= din.y - (din.x >>> IDX);
			z_q <= din.z + ATAN_Q30[IDX];
		end else begin
			x_q <= din.x - (din.y >>> IDX);
			y_q <= din.y + (din.x >>> IDX);
			z_q <= din.z - ATAN_Q30[IDX];
		end
	end

	assign dout = '{valid: valid_q, zero: zero_q, x: x_q, y: y_q, z: z_q};

endmodule

FILE: rtl/ptpc_cordic_chain.sv
`include "assert_macros.svh"

module ptpc_cordic_chain #(
	parameter int CORDIC_STEPS = ptpc_pkg::DEF_CORDIC_STEPS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ptpc_pkg::vec_t   din,
	output ptpc_pkg::vec_t   dout
);
	import ptpc_pkg::*;

	localparam int N = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

	vec_t          link [N+1];
	logic [N-1:0]  busy;

	assign link[0] = din;

	for (genvar i = 0; i < N; i++) begin : g_cell
		ptpc_cordic_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (link[i]),
			.dout   (link[i+1])
		);
		assign busy[i] = link[i+1].valid;
	end

	assign dout = link[N];

	// one vector in flight at a time
	`ASSERT_ALWAYS(a_single_word, clk, arst_n, $onehot0(busy))
	`ASSERT_IMPL(a_walk, clk, arst_n, din.valid, ##N dout.valid)

endmodule

FILE: rtl/pan_tilt_pointing_controller.sv
// Channel  | Handshake              | Word
// ---------+------------------------+----------------------------------------------
// in       | in_valid / in_stall    | operation, point_x/y/z, yaw_angle, pitch_angle
// out      | out_valid / out_stall  | is_velocity, target_accepted, yaw/pitch_velocity
// cfg      | APB psel/penable/...   | yaw_gain @0x0, pitch_gain @0x4, min_horizontal @0x8
//
// One word is worked at a time; the next is taken after the output register is
// loaded. Aim word: two walks down the chain of N CORDIC cells (N = CORDIC steps,
// capped at 24), with the split multiply and compare for the distance gain
// (S_MUL_LO, S_MUL_HI, S_SUM) between them; a rejected point skips the second walk.
// Control tick: gain multiply at accept, then round/saturate in S_VEL.
// The output register decouples the sides: a new word is taken while a result
// waits; a stalled full output register holds the last step of the next word.
// Reset clears control state and targets; gains and min_horizontal return to defaults.
`include "assert_macros.svh"

module pan_tilt_pointing_controller #(
	parameter int CORDIC_STEPS = ptpc_pkg::DEF_CORDIC_STEPS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_z,
	input  logic signed [15:0]  yaw_angle,
	input  logic signed [15:0]  pitch_angle,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                is_velocity,
	output logic                target_accepted,
	output logic signed [23:0]  yaw_velocity,
	output logic signed [23:0]  pitch_velocity,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import ptpc_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_YAW    = 3'd1;
	localparam logic [2:0] S_MUL_LO = 3'd2;
	localparam logic [2:0] S_MUL_HI = 3'd3;
	localparam logic [2:0] S_SUM    = 3'd4;
	localparam logic [2:0] S_PITCH  = 3'd5;
	localparam logic [2:0] S_VEL    = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	localparam logic [1:0] REG_YAW_GAIN   = 2'd0;
	localparam logic [1:0] REG_PITCH_GAIN = 2'd1;
	localparam logic [1:0] REG_MIN_HORIZ  = 2'd2;

	// configuration
	logic [15:0] yaw_gain_q, pitch_gain_q;
	logic [30:0] min_h_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_gain_q   <= 16'd256;
			pitch_gain_q <= 16'd256;
			min_h_q      <= 31'd6554;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_YAW_GAIN:   yaw_gain_q   <= pwdata[15:0];
				REG_PITCH_GAIN: pitch_gain_q <= pwdata[15:0];
				REG_MIN_HORIZ:  min_h_q      <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_YAW_GAIN:   prdata = {16'd0, yaw_gain_q};
			REG_PITCH_GAIN: prdata = {16'd0, pitch_gain_q};
			REG_MIN_HORIZ:  prdata = {1'b0, min_h_q};
			default:        prdata = '0;
		endcase
	end

	// sequencer and datapath state
	logic [2:0]             state_q;
	logic signed [15:0]     yaw_tgt_q, pitch_tgt_q;
	logic signed [XW-1:0]   pz_q;
	logic signed [ZW-1:0]   yaw_a_q;
	logic [32:0]            raw_q;
	logic [46:0]            plo_q;
	logic [45:0]            phi_q;
	logic signed [33:0]     yprod_q, pprod_q;
	logic                   res_vel_q, res_ok_q;
	logic signed [23:0]     res_yv_q, res_pv_q;
	logic                   out_valid_q, out_vel_q, out_ok_q;
	logic signed [23:0]     out_yv_q, out_pv_q;

	logic                   in_take;
	logic                   out_free;
	vec_t                   chain_in, chain_out;
	logic [63:0]            hsum;
	logic [32:0]            h;
	logic                   h_ok;
	logic signed [16:0]     ydiff, pdiff;
	logic signed [34:0]     yneg, pneg, yrnd, prnd;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// distance gain: raw * K split into two partial products
	assign hsum = {phi_q, 17'd0} + {17'd0, plo_q} + 64'd536870912;
	assign h    = hsum[62:30];
	assign h_ok = h >= {2'd0, min_h_q};

	always_comb begin
		chain_in = '0;
		if (in_take && !operation) begin
			chain_in = cordic_prep(XW'(point_x), XW'(point_y));
		end else if (state_q == S_SUM && h_ok) begin
			chain_in = cordic_prep($signed({3'd0, h}), pz_q);
		end
	end

	ptpc_cordic_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (chain_in),
		.dout   (chain_out)
	);

	// velocity: -(angle - target) * gain
	assign ydiff = 17'(yaw_angle) - 17'(yaw_tgt_q);
	assign pdiff = 17'(pitch_angle) - 17'(pitch_tgt_q);
	assign yneg  = -35'(yprod_q);
	assign pneg  = -35'(pprod_q);
	assign yrnd  = (yneg + 35'sd128) >>> 8;
	assign prnd  = (pneg + 35'sd128) >>> 8;

	function automatic logic signed [23:0] sat24(logic signed [34:0] v);
		if (v > 35'sd8388607)
			return 24'sh7FFFFF;
		else if (v < -35'sd8388608)
			return 24'sh800000;
		else
			return v[23:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			yaw_tgt_q   <= '0;
			pitch_tgt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take)
						state_q <= operation ? S_VEL : S_YAW;
				end
				S_YAW: begin
					if (chain_out.valid)
						state_q <= S_MUL_LO;
				end
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_SUM;
				S_SUM:    state_q <= h_ok ? S_PITCH : S_DONE;
				S_PITCH: begin
					if (chain_out.valid) begin
						yaw_tgt_q   <= q30_to_q12(XW'(yaw_a_q));
						pitch_tgt_q <= chain_out.zero ? 16'sd0 :
							q30_to_q12(-XW'(chain_out.z));
						state_q     <= S_DONE;
					end
				end
				S_VEL:    state_q <= S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pz_q    <= XW'(point_z);
			yprod_q <= ydiff * $signed({1'b0, yaw_gain_q});
			pprod_q <= pdiff * $signed({1'b0, pitch_gain_q});
			res_vel_q <= operation;
			res_ok_q  <= 1'b0;
			res_yv_q  <= '0;
			res_pv_q  <= '0;
		end
		if (state_q == S_YAW && chain_out.valid) begin
			raw_q   <= chain_out.zero ? 33'd0 : chain_out.x[32:0];
			yaw_a_q <= chain_out.zero ? '0 : chain_out.z;
		end
		if (state_q == S_MUL_LO)
			plo_q <= raw_q[16:0] * INV_GAIN_Q30;
		if (state_q == S_MUL_HI)
			phi_q <= raw_q[32:17] * INV_GAIN_Q30;
		if (state_q == S_SUM)
			res_ok_q <= h_ok;
		if (state_q == S_VEL) begin
			res_yv_q <= sat24(yrnd);
			res_pv_q <= sat24(prnd);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_vel_q <= res_vel_q;
			out_ok_q  <= res_ok_q;
			out_yv_q  <= res_yv_q;
			out_pv_q  <= res_pv_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign is_velocity     = out_vel_q;
	assign target_accepted = out_ok_q;
	assign yaw_velocity    = out_yv_q;
	assign pitch_velocity  = out_pv_q;

	`ASSERT_IMPL(a_chain_busy, clk, arst_n, chain_out.valid,
		(state_q == S_YAW) || (state_q == S_PITCH))
	`ASSERT_IMPL(a_ok_not_vel, clk, arst_n, out_valid_q && out_ok_q, !out_vel_q)
	`ASSERT_IMPL(a_rejected_no_pitch, clk, arst_n,
		(state_q == S_SUM) && !h_ok, ##1 (state_q == S_DONE) && !res_ok_q)

endmodule

FILE: tb/pointing_checker.sv
module pointing_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               operation,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [15:0] yaw_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               is_velocity,
	input  logic               target_accepted,
	input  logic signed [23:0] yaw_velocity,
	input  logic signed [23:0] pitch_velocity,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] ADDR_YAW_GAIN = 4'h0;
	localparam logic [3:0] ADDR_PITCH_GAIN = 4'h4;
	localparam logic [3:0] ADDR_MIN_HORIZ = 4'h8;
	localparam logic OP_AIM = 1'b0;
	localparam int STEPS = 16;

	typedef struct packed {
		logic               vel;
		logic               acc;
		logic signed [23:0] yv;
		logic signed [23:0] pv;
	} word_t;

	word_t expected_words[$];
	logic [15:0] yaw_gain_m, pitch_gain_m;
	logic [30:0] min_horiz_m;
	logic signed [15:0] yaw_tgt, pitch_tgt;

	// arithmetic shift with floor, safe on longint
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint cordic_angle(longint x, longint y, output longint mag);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		if (x < 0) begin
			z = (y >= 0) ? ptpc_pkg::PI_Q30 : -longint'(ptpc_pkg::PI_Q30);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += ptpc_pkg::ATAN_Q30[i];
			end else begin
				x -= dx; y += dy; z -= ptpc_pkg::ATAN_Q30[i];
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic logic signed [15:0] to_q12(longint a);
		longint t;
		t = floor_shift(a + (64'sd1 <<< 17), 18);
		return t[15:0];
	endfunction

	function automatic logic signed [23:0] command(longint ang, longint tgt, longint g);
		longint v;
		v = floor_shift(-((ang - tgt) * g) + 128, 8);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	function automatic word_t predict_pointing(logic op, longint x, longint y, longint z,
			longint ya, longint pa);
		word_t w;
		longint raw, dummy, h, ya_q30, pa_q30;
		w = '0;
		if (op == OP_AIM) begin
			ya_q30 = cordic_angle(x, y, raw);
			h = longint'((longint'(unsigned'(raw)) * 652032874 + (64'sd1 <<< 29)) >>> 30);
			w.acc = h >= longint'(min_horiz_m);
			if (w.acc) begin
				pa_q30 = cordic_angle(h, z, dummy);
				yaw_tgt = to_q12(ya_q30);
				pitch_tgt = to_q12(-pa_q30);
			end
		end else begin
			w.vel = 1'b1;
			w.yv = command(ya, yaw_tgt, yaw_gain_m);
			w.pv = command(pa, pitch_tgt, pitch_gain_m);
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t got, want;
		if (!arst_n) begin
			expected_words.delete();
			fail_count <= 0;
			pending_count <= 0;
			yaw_gain_m <= 16'd256;
			pitch_gain_m <= 16'd256;
			min_horiz_m <= 31'd6554;
			yaw_tgt = '0;
			pitch_tgt = '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_YAW_GAIN: yaw_gain_m <= pwdata[15:0];
					ADDR_PITCH_GAIN: pitch_gain_m <= pwdata[15:0];
					ADDR_MIN_HORIZ: min_horiz_m <= pwdata[30:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_words.push_back(predict_pointing(operation, point_x, point_y,
					point_z, yaw_angle, pitch_angle));
			if (out_valid && !out_stall) begin
				got = '{is_velocity, target_accepted, yaw_velocity, pitch_velocity};
				if (expected_words.size() == 0) begin
					if (fail_count < 10) $display("unexpected result word %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: exp vel=%0b acc=%0b yv=%0d pv=%0d, got vel=%0b acc=%0b yv=%0d pv=%0d",
								want.vel, want.acc, want.yv, want.pv,
								got.vel, got.acc, got.yv, got.pv);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= expected_words.size();
		end
	end
endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] ADDR_YAW_GAIN = 4'h0;
	localparam logic [3:0] ADDR_PITCH_GAIN = 4'h4;
	localparam logic [3:0] ADDR_MIN_HORIZ = 4'h8;
	localparam logic OP_AIM = 1'b0;
	localparam logic OP_TICK = 1'b1;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;   // idle time after the checker queue empties

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, operation = 0;
	logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
	logic signed [15:0] yaw_angle = 0, pitch_angle = 0;
	logic out_valid, out_stall = 0, is_velocity, target_accepted;
	logic signed [23:0] yaw_velocity, pitch_velocity;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	int fail_count, pending_count;
	int idle_cycles = 0;
	bit quiet_phase = 0;    // long stretch with no gaps on either side

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	pan_tilt_pointing_controller uut (.*);
	pointing_checker chk (.*);

	// Receiver stalls at random, except in the quiet stretch.
	always @(posedge clk)
		out_stall <= !quiet_phase && ($urandom_range(99) < 11);

	// Watchdog: cycles with no accepted word on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic reg_write(logic [3:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Present one word, hold it until accepted, maybe idle afterwards.
	task automatic send_word(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] ya, logic [15:0] pa);
		in_valid <= 1; operation <= op;
		point_x <= x; point_y <= y; point_z <= z;
		yaw_angle <= ya; pitch_angle <= pa;
		do @(posedge clk); while (in_stall);
		while (!quiet_phase && $urandom_range(99) < 11) begin
			in_valid <= 0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2 * 65536 * 20)) - 65536 * 20;
			2: return $signed($urandom_range(20000)) - 10000;
			default: return $signed($urandom_range(131072)) - 65536;
		endcase
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(2) == 0)
				send_word(OP_AIM, rand_coord(), rand_coord(), rand_coord(),
					16'($urandom), 16'($urandom));
			else
				send_word(OP_TICK, $urandom, $urandom, $urandom,
					16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset defaults, zero vector, axis points, extremes.
		send_word(OP_TICK, 0, 0, 0, 16'sh7fff, 16'sh8000);
		send_word(OP_AIM, 0, 0, 0, 0, 0);                       // zero vector, rejected
		send_word(OP_AIM, 32'h0001_0000, 0, 0, 0, 0);           // on x axis, zero elevation
		send_word(OP_AIM, 32'hffff_0000, 0, 32'h0001_0000, 0, 0); // left half, y = 0
		send_word(OP_AIM, 32'hffff_0000, 32'hffff_ffff, 0, 0, 0); // left half, y < 0
		send_word(OP_TICK, 0, 0, 0, 0, 0);
		send_word(OP_AIM, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
		send_word(OP_TICK, 0, 0, 0, 16'sh8000, 16'sh7fff);
		send_word(OP_AIM, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
		send_word(OP_AIM, 0, 32'd100, 0, 0, 0);                 // too close, rejected
		send_word(OP_AIM, 0, 32'h0000_2000, 32'h7fff_ffff, 0, 0);
		send_word(OP_TICK, 0, 0, 0, 16'h1234, 16'hedcb);
		drain();

		reg_write(ADDR_YAW_GAIN, 32'hffff);
		reg_write(ADDR_PITCH_GAIN, 32'hffff);
		reg_write(ADDR_MIN_HORIZ, 32'h0);
		send_word(OP_AIM, 0, 0, 32'h0001_0000, 0, 0);           // zero vector accepted
		send_word(OP_TICK, 0, 0, 0, 16'sh7fff, 16'sh8000);      // large errors at full gain
		send_word(OP_TICK, 0, 0, 0, 16'sh8000, 16'sh7fff);
		send_word(OP_AIM, 32'h0005_0000, 32'hfffb_0000, 32'hfff0_0000, 0, 0);
		send_word(OP_TICK, 0, 0, 0, 0, 0);
		drain();

		reg_write(ADDR_YAW_GAIN, 32'h0);
		reg_write(ADDR_PITCH_GAIN, 32'h0);
		reg_write(ADDR_MIN_HORIZ, 32'h7fff_ffff);
		send_word(OP_AIM, 32'h7fff_ffff, 0, 0, 0, 0);
		send_word(OP_TICK, 0, 0, 0, 16'h4000, 16'hc000);
		drain();

		// Random phases across register settings; one runs with no gaps at all.
		for (int ph = 0; ph < 6; ph++) begin
			reg_write(ADDR_YAW_GAIN, $urandom & 32'hffff);
			reg_write(ADDR_PITCH_GAIN, $urandom & 32'hffff);
			reg_write(ADDR_MIN_HORIZ, $urandom_range(3) == 0 ? $urandom : $urandom_range(200000));
			quiet_phase = (ph == 3);
			random_phase(65);
			quiet_phase = 0;
			drain();
		end

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
